### sv/cts_pkg.sv
package cts_pkg;

	// default table size and dispatch result limit
	localparam int TASK_SLOTS_DEF = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);

	localparam int HANDLE_W = 8;
	localparam int TIME_W   = 16;
	localparam int PEND_W   = 8;
	localparam int SLOTID_W = 3;

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_DELETE   = 2'd2,
		MODE_DISPATCH = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_ADD  = 3'd0,
		KIND_DEL  = 3'd1,
		KIND_RUN  = 3'd2,
		KIND_TICK = 3'd3,
		KIND_IDLE = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// contents of one task slot
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   delay;
		logic [TIME_W-1:0]   period;
		logic [PEND_W-1:0]   pend;
	} slot_t;

	// operation applied to the slot that passes the head of the ring
	typedef struct packed {
		mode_t               mode;
		logic                apply;
		logic                add_here;
		logic                del_here;
		logic                run_here;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   delay;
		logic [TIME_W-1:0]   period;
	} cell_ctl_t;

endpackage

### sv/cts_if.sv
interface cts_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         mode;
	logic [cts_pkg::HANDLE_W-1:0]       task_handle;
	logic [cts_pkg::TIME_W-1:0]         start_delay;
	logic [cts_pkg::TIME_W-1:0]         period;
	logic [cts_pkg::SLOTID_W-1:0]       slot;

	modport source (output valid, mode, task_handle, start_delay, period, slot,
		input ready);
	modport sink (input valid, mode, task_handle, start_delay, period, slot,
		output ready);
endinterface

interface cts_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [2:0]                         kind;
	logic [cts_pkg::SLOTID_W-1:0]       slot_out;
	logic [cts_pkg::HANDLE_W-1:0]       handle_out;
	logic [1:0]                         status;
	logic                               last;

	modport source (output valid, kind, slot_out, handle_out, status, last,
		input ready);
	modport sink (input valid, kind, slot_out, handle_out, status, last,
		output ready);
endinterface

### sv/cts_cell.sv
module cts_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  cts_pkg::cell_ctl_t ctl,
	input  cts_pkg::slot_t     nb,
	output cts_pkg::slot_t     q
);
	import cts_pkg::*;

	slot_t upd;
	slot_t cur_q;

	// update of the slot taken from the head when this cell is the ring's tail
	always_comb begin
		upd = nb;
		if (ctl.apply) begin
			unique case (ctl.mode)
				MODE_TICK: begin
					if (nb.handle != '0) begin
						if (nb.delay == '0) begin
							if (nb.pend != '1)
								upd.pend = nb.pend + PEND_W'(1);
							if (nb.period != '0)
								upd.delay = nb.period;
						end else begin
							upd.delay = nb.delay - TIME_W'(1);
						end
					end
				end
				MODE_ADD: begin
					if (ctl.add_here) begin
						upd.handle = ctl.handle;
						upd.delay  = ctl.delay;
						upd.period = ctl.period;
						upd.pend   = '0;
					end
				end
				MODE_DELETE: begin
					if (ctl.del_here)
						upd = '0;
				end
				MODE_DISPATCH: begin
					if (ctl.run_here) begin
						if (nb.period == '0)
							upd = '0;
						else
							upd.pend = nb.pend - PEND_W'(1);
					end
				end
				default: upd = nb;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (shift) begin
			cur_q <= upd;
		end
	end

	assign q = cur_q;

endmodule

### sv/cooperative_task_scheduler.sv
// cooperative task scheduler
//
// req channel (sink): one command per transfer, mode selects tick, add,
// delete or dispatch; task_handle, start_delay and period serve add, slot
// serves delete. rsp channel (source): result transfers, last marks the
// final result of a command. add, delete and tick give one result each,
// dispatch gives one run result per slot with pending runs (at most
// MAX_RESULTS) or a single nothing-ready result.
//
// the task slots sit in a ring of cells that rotates one place per cycle
// unless a further run result must leave while rsp holds the last one;
// every command walks the whole ring once: the run state rotates it, the
// flush state hands over the final result and the idle state takes the
// next command. dispatch runs that are followed by more runs leave as
// results before the walk ends.
//
// reset clears every slot (all empty) and the output valid flag. a stalled
// rsp holds the result in the output register; the ring stops rotating
// only when a further result must be handed out, and req stays not ready
// until the command is complete.
module cooperative_task_scheduler #(
	parameter int TASK_SLOTS = cts_pkg::TASK_SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cts_req_if.sink   req,
	cts_rsp_if.source rsp
);
	import cts_pkg::*;

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;

	// latched command
	mode_t                mode_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [TIME_W-1:0]    delay_q;
	logic [TIME_W-1:0]    period_q;
	logic [SLOTID_W-1:0]  slot_q;

	// position of the slot currently at the ring head
	logic [IW-1:0]        idx_q;

	// per-command scan results
	logic                 found_q;
	logic [IW-1:0]        found_slot_q;
	logic                 del_ok_q;
	logic [RES_CNT_W-1:0] n_q;
	logic                 held_valid_q;
	logic [SLOTID_W-1:0]  held_slot_q;
	logic [HANDLE_W-1:0]  held_handle_q;

	// output register
	logic                 out_valid_q;
	kind_t                out_kind_q;
	logic [SLOTID_W-1:0]  out_slot_q;
	logic [HANDLE_W-1:0]  out_handle_q;
	status_t              out_status_q;
	logic                 out_last_q;

	slot_t                cell_q [TASK_SLOTS];
	cell_ctl_t            ctl_base;
	cell_ctl_t            cell_ctl [TASK_SLOTS];
	slot_t                head;

	logic accept;
	logic out_free;
	logic last_step;
	logic run_hit;
	logic push;
	logic shift;
	logic flush_go;

	assign head      = cell_q[0];
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign last_step = (idx_q == IW'(TASK_SLOTS - 1));

	// a dispatch run at the head; the previous run leaves as a non-final result
	assign run_hit  = (mode_q == MODE_DISPATCH) && (head.pend != '0) &&
		(n_q < RES_CNT_W'(MAX_RESULTS));
	assign push     = run_hit && held_valid_q;
	assign shift    = (state_q == ST_RUN) && (!push || out_free);
	assign flush_go = (state_q == ST_FLUSH) && out_free;

	always_comb begin
		ctl_base          = '0;
		ctl_base.mode     = mode_q;
		ctl_base.handle   = handle_q;
		ctl_base.delay    = delay_q;
		ctl_base.period   = period_q;
		ctl_base.add_here = !found_q && (head.handle == '0) && (handle_q != '0);
		ctl_base.del_here = (32'(idx_q) == 32'(slot_q)) && (head.handle != '0);
		ctl_base.run_here = run_hit;
	end

	// ring of slot cells: cell i takes cell i+1, the tail takes the updated head
	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_ring
		always_comb begin
			cell_ctl[i]       = ctl_base;
			cell_ctl[i].apply = (i == TASK_SLOTS - 1);
		end

		cts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.ctl    (cell_ctl[i]),
			.nb     (cell_q[(i + 1) % TASK_SLOTS]),
			.q      (cell_q[i])
		);
	end

	// command sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			found_slot_q <= '0;
			del_ok_q     <= 1'b0;
			n_q          <= '0;
			held_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_RUN;
						idx_q        <= '0;
						found_q      <= 1'b0;
						found_slot_q <= '0;
						del_ok_q     <= 1'b0;
						n_q          <= '0;
						held_valid_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (shift) begin
						if (mode_q == MODE_ADD && !found_q && head.handle == '0) begin
							found_q      <= 1'b1;
							found_slot_q <= idx_q;
						end
						if (mode_q == MODE_DELETE && 32'(idx_q) == 32'(slot_q))
							del_ok_q <= (head.handle != '0);
						if (run_hit) begin
							held_valid_q <= 1'b1;
							n_q          <= n_q + RES_CNT_W'(1);
						end
						if (last_step) begin
							idx_q   <= '0;
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (flush_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command payload and held run result
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_t'(req.mode);
			handle_q <= req.task_handle;
			delay_q  <= req.start_delay;
			period_q <= req.period;
			slot_q   <= req.slot;
		end
		if (shift && run_hit) begin
			held_slot_q   <= SLOTID_W'(idx_q);
			held_handle_q <= head.handle;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flush_go || (shift && push)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && push) begin
			out_kind_q   <= KIND_RUN;
			out_slot_q   <= held_slot_q;
			out_handle_q <= held_handle_q;
			out_status_q <= STAT_OK;
			out_last_q   <= 1'b0;
		end else if (flush_go) begin
			out_handle_q <= '0;
			out_status_q <= STAT_OK;
			out_last_q   <= 1'b1;
			out_slot_q   <= '0;
			unique case (mode_q)
				MODE_TICK: begin
					out_kind_q <= KIND_TICK;
				end
				MODE_ADD: begin
					out_kind_q <= KIND_ADD;
					if (found_q)
						out_slot_q <= SLOTID_W'(found_slot_q);
					else
						out_status_q <= STAT_FULL;
				end
				MODE_DELETE: begin
					out_kind_q   <= KIND_DEL;
					out_slot_q   <= slot_q;
					out_status_q <= del_ok_q ? STAT_OK : STAT_EMPTY;
				end
				MODE_DISPATCH: begin
					if (held_valid_q) begin
						out_kind_q   <= KIND_RUN;
						out_slot_q   <= held_slot_q;
						out_handle_q <= held_handle_q;
					end else begin
						out_kind_q <= KIND_IDLE;
					end
				end
				default: out_kind_q <= KIND_IDLE;
			endcase
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.slot_out   = out_slot_q;
	assign rsp.handle_out = out_handle_q;
	assign rsp.status     = out_status_q;
	assign rsp.last       = out_last_q;

	// the ring is back at its home position whenever no command is walking it
	a_idx_home: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> state_q == ST_RUN)
		else $error("ring position moved outside a command walk");

	// a dispatch never issues more runs than the result limit
	a_run_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("dispatch run count above limit");

	// completing a command always leaves a final result in the output register
	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		flush_go |=> rsp.valid && rsp.last && state_q == ST_IDLE)
		else $error("command finished without a final result");

	// a run leaves early only while another run is held behind it
	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		shift && push |=> held_valid_q && rsp.valid && !rsp.last)
		else $error("early run result without held successor");

endmodule
